### rtl/qslerp_pkg.sv
// Shared types, constants and helper functions for the quaternion slerp pipeline.
// Used by every module under rtl except qslerp_isqrt; depends on nothing else.
package qslerp_pkg;

    localparam int Q_ONE      = 16384;
    localparam int ROUND_HALF = 8192;
    localparam int DIV_BITS   = 15;
    localparam int ATAN_LEN   = 24;

    localparam logic [14:0] THRESHOLD_RESET = 15'd16302;

    // Configuration port geometry: one register, selected by the word index bit.
    localparam int   APB_ADDR_W           = 3;
    localparam int   APB_DATA_W           = 32;
    localparam logic REG_LINEAR_THRESHOLD = 1'b0;

    // atan(2^-i) scaled by 2^32
    localparam logic [31:0] ATAN_Q32 [ATAN_LEN] = '{
        32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
        32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
        32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
        32'd1048576,    32'd524288,     32'd262144,     32'd131072,
        32'd65536,      32'd32768,      32'd16384,      32'd8192,
        32'd4096,       32'd2048,       32'd1024,       32'd512
    };

    typedef enum logic {
        CORDIC_VECTOR,
        CORDIC_ROTATE
    } cordic_mode_t;

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] a_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] b_w;
        logic [14:0]        blend;
    } req_t;

    typedef struct packed {
        logic signed [15:0] r_x;
        logic signed [15:0] r_y;
        logic signed [15:0] r_z;
        logic signed [15:0] r_w;
    } rsp_t;

    // Operands that ride alongside the angle datapath until the final blend.
    typedef struct packed {
        logic [3:0][16:0] a;
        logic [3:0][15:0] b;
        logic [14:0]      t;
        logic             lin;
    } carry_t;

    // Arctangent constant rounded to frac fraction bits.
    function automatic logic [32:0] atan_step(int i, int frac);
        logic [32:0] v;
        int          sh;
        v  = {1'b0, ATAN_Q32[i]};
        sh = 32 - frac;
        if (sh > 0)
        begin
            v = (v + (33'd1 << (sh - 1))) >> sh;
        end
        return v;
    endfunction

endpackage

### rtl/qslerp_front.sv
// Front end of the slerp pipeline: dot product, hemisphere flip, rounding and 1 - dot^2.
// Four register stages; uses qslerp_pkg.
module qslerp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  qslerp_pkg::req_t    in_data,
    input  logic [14:0]         threshold,
    output logic                out_valid,
    output logic [28:0]         out_rad,
    output logic [13:0]         out_dot,
    output qslerp_pkg::carry_t  out_carry
);

    logic [3:0] v_reg;

    logic signed [15:0] a1_reg [4];
    logic signed [15:0] b1_reg [4];
    logic signed [31:0] p1_reg [4];
    logic [14:0]        t1_reg;

    logic signed [15:0] a2_reg [4];
    logic signed [15:0] b2_reg [4];
    logic [14:0]        t2_reg;
    logic signed [33:0] sum2_reg;

    qslerp_pkg::carry_t carry3_reg;
    logic [13:0]        d3_reg;

    qslerp_pkg::carry_t carry4_reg;
    logic [13:0]        d4_reg;
    logic [28:0]        rad4_reg;

    logic signed [15:0] a_in [4];
    logic signed [15:0] b_in [4];
    logic [14:0]        t_clamp;
    logic signed [33:0] sum_next;
    logic               neg;
    logic [33:0]        mag;
    logic [33:0]        rounded;
    logic [19:0]        dval;
    qslerp_pkg::carry_t carry3_next;
    logic [27:0]        dsq;
    logic [28:0]        rad_next;

    assign a_in = '{in_data.a_x, in_data.a_y, in_data.a_z, in_data.a_w};
    assign b_in = '{in_data.b_x, in_data.b_y, in_data.b_z, in_data.b_w};
    assign t_clamp = (in_data.blend > 15'(qslerp_pkg::Q_ONE)) ? 15'(qslerp_pkg::Q_ONE)
                                                              : in_data.blend;

    assign sum_next = 34'(p1_reg[0]) + 34'(p1_reg[1]) + 34'(p1_reg[2]) + 34'(p1_reg[3]);

    // The sign is taken from the exact sum, before rounding.
    assign neg     = sum2_reg[33];
    assign mag     = neg ? 34'(-sum2_reg) : 34'(sum2_reg);
    assign rounded = mag + 34'(qslerp_pkg::ROUND_HALF);
    assign dval    = rounded[33:14];

    always_comb
    begin
        carry3_next.t   = t2_reg;
        carry3_next.lin = !((dval < 20'(threshold)) && (dval < 20'(qslerp_pkg::Q_ONE)));
        for (int k = 0; k < 4; k++)
        begin
            carry3_next.a[k] = neg ? 17'(-17'(a2_reg[k])) : 17'(a2_reg[k]);
            carry3_next.b[k] = b2_reg[k];
        end
    end

    assign dsq      = 28'(d3_reg) * 28'(d3_reg);
    assign rad_next = (29'd1 << 28) - 29'(dsq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                a1_reg[k] <= a_in[k];
                b1_reg[k] <= b_in[k];
                p1_reg[k] <= a_in[k] * b_in[k];
                a2_reg[k] <= a1_reg[k];
                b2_reg[k] <= b1_reg[k];
            end
            t1_reg     <= t_clamp;
            t2_reg     <= t1_reg;
            sum2_reg   <= sum_next;
            carry3_reg <= carry3_next;
            d3_reg     <= dval[13:0];
            carry4_reg <= carry3_reg;
            d4_reg     <= d3_reg;
            rad4_reg   <= rad_next;
        end
    end

    assign out_valid = v_reg[3];
    assign out_rad   = rad4_reg;
    assign out_dot   = d4_reg;
    assign out_carry = carry4_reg;

endmodule

### rtl/qslerp_isqrt.sv
// Pipelined floor integer square root, one root bit per register stage.
// Carries an opaque side word alongside; uses no package items.
module qslerp_isqrt #(
    parameter int NB     = 33,
    parameter int SIDE_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [NB-1:0]         in_n,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [(NB+1)/2-1:0]   out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int RB = (NB + 1) / 2;
    localparam int XW = NB + 2;

    logic [RB-1:0]     v_reg;
    logic [NB-1:0]     n_reg    [RB];
    logic [RB-1:0]     r_reg    [RB];
    logic [SIDE_W-1:0] side_reg [RB];
    logic [NB-1:0]     n_next   [RB];
    logic [RB-1:0]     r_next   [RB];

    for (genvar s = 0; s < RB; s++)
    begin : g_stage
        localparam int BIT = RB - 1 - s;
        logic [NB-1:0] nc;
        logic [RB-1:0] rc;
        logic [XW-1:0] cand;
        logic          take;

        if (s == 0)
        begin : g_first
            assign nc = in_n;
            assign rc = '0;
        end
        else
        begin : g_rest
            assign nc = n_reg[s-1];
            assign rc = r_reg[s-1];
        end

        // Trial subtrahend (4r + 1) * 4^bit for setting this root bit.
        assign cand      = ((XW'(rc) << 2) | XW'(1)) << (2 * BIT);
        assign take      = XW'(nc) >= cand;
        assign n_next[s] = take ? (nc - cand[NB-1:0]) : nc;
        assign r_next[s] = (rc << 1) | RB'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[RB-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_side;
            for (int s = 0; s < RB; s++)
            begin
                n_reg[s] <= n_next[s];
                r_reg[s] <= r_next[s];
            end
            for (int s = 1; s < RB; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[RB-1];
    assign out_root  = r_reg[RB-1];
    assign out_side  = side_reg[RB-1];

endmodule

### rtl/qslerp_cordic.sv
// Unrolled CORDIC, one micro-rotation per register stage, over one or more lanes.
// Vectoring mode returns the angle, rotation mode the y word; uses qslerp_pkg.
module qslerp_cordic #(
    parameter int                       W      = 19,
    parameter int                       STEPS  = 16,
    parameter int                       FRAC   = 16,
    parameter int                       LANES  = 1,
    parameter int                       SIDE_W = 8,
    parameter qslerp_pkg::cordic_mode_t MODE   = qslerp_pkg::CORDIC_ROTATE
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [LANES-1:0][W-1:0]      in_x,
    input  logic [LANES-1:0][W-1:0]      in_y,
    input  logic [LANES-1:0][W-1:0]      in_z,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [LANES-1:0][W-1:0]      out_res,
    output logic [SIDE_W-1:0]            out_side
);

    logic [STEPS-1:0]          v_reg;
    logic [LANES-1:0][W-1:0]   x_reg    [STEPS];
    logic [LANES-1:0][W-1:0]   y_reg    [STEPS];
    logic [LANES-1:0][W-1:0]   z_reg    [STEPS];
    logic [SIDE_W-1:0]         side_reg [STEPS];
    logic [LANES-1:0][W-1:0]   x_next   [STEPS];
    logic [LANES-1:0][W-1:0]   y_next   [STEPS];
    logic [LANES-1:0][W-1:0]   z_next   [STEPS];

    for (genvar s = 0; s < STEPS; s++)
    begin : g_stage
        localparam logic signed [W-1:0] ANGLE = W'(qslerp_pkg::atan_step(s, FRAC));
        logic [LANES-1:0][W-1:0] cx, cy, cz, nx, ny, nz;

        if (s == 0)
        begin : g_first
            assign cx = in_x;
            assign cy = in_y;
            assign cz = in_z;
        end
        else
        begin : g_rest
            assign cx = x_reg[s-1];
            assign cy = y_reg[s-1];
            assign cz = z_reg[s-1];
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic signed [W-1:0] xs, ys, zs, dx, dy;
            logic                m;

            assign xs = cx[l];
            assign ys = cy[l];
            assign zs = cz[l];
            assign dx = ys >>> s;
            assign dy = xs >>> s;

            // m set: x gains dx, y loses dy, the angle grows.
            if (MODE == qslerp_pkg::CORDIC_VECTOR)
            begin : g_vec
                assign m = ys > 0;
            end
            else
            begin : g_rot
                assign m = zs < 0;
            end

            assign nx[l] = m ? (xs + dx) : (xs - dx);
            assign ny[l] = m ? (ys - dy) : (ys + dy);
            assign nz[l] = m ? (zs + ANGLE) : (zs - ANGLE);
        end

        assign x_next[s] = nx;
        assign y_next[s] = ny;
        assign z_next[s] = nz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_side;
            for (int s = 0; s < STEPS; s++)
            begin
                x_reg[s] <= x_next[s];
                y_reg[s] <= y_next[s];
                z_reg[s] <= z_next[s];
            end
            for (int s = 1; s < STEPS; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    if (MODE == qslerp_pkg::CORDIC_VECTOR)
    begin : g_out_angle
        assign out_res = z_reg[STEPS-1];
    end
    else
    begin : g_out_sine
        assign out_res = y_reg[STEPS-1];
    end

    assign out_valid = v_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

### rtl/qslerp_weight.sv
// Blend weights from the sine ratios: a check stage, then a restoring divider
// with one quotient bit per stage for each of the two weights; uses qslerp_pkg.
module qslerp_weight #(
    parameter int W = 19
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [2:0][W-1:0]   in_sine,
    input  qslerp_pkg::carry_t  in_carry,
    output logic                out_valid,
    output logic [14:0]         out_wa,
    output logic [14:0]         out_wb,
    output qslerp_pkg::carry_t  out_carry
);

    localparam int NW = W + 15;
    localparam int NS = qslerp_pkg::DIV_BITS + 1;

    logic [NS-1:0]          v_reg;
    logic [1:0][NW-1:0]     rem_reg   [NS];
    logic [1:0][14:0]       q_reg     [NS];
    logic [1:0]             neg_reg   [NS];
    logic [1:0]             sat_reg   [NS];
    logic [NW-1:0]          den_reg   [NS];
    logic                   lin_reg   [NS];
    qslerp_pkg::carry_t     carry_reg [NS];

    logic [1:0][NW-1:0]     rem_next  [NS];
    logic [1:0][14:0]       q_next    [NS];
    logic [1:0]             neg_in;
    logic [1:0]             sat_in;
    logic [NW-1:0]          den_in;
    logic                   lin_in;

    assign den_in = NW'(in_sine[0]);
    // A sine of theta that is not positive falls back to linear blending.
    assign lin_in = in_carry.lin || !($signed(in_sine[0]) > 0);

    for (genvar l = 0; l < 2; l++)
    begin : g_check
        logic [NW-1:0] num;
        assign num       = NW'(in_sine[l+1]);
        assign neg_in[l] = in_sine[l+1][W-1];
        assign rem_next[0][l] = (num << 14) + (den_in >> 1);
        assign sat_in[l] = rem_next[0][l] >= ((den_in << 14) + den_in);
        assign q_next[0][l] = '0;
    end

    for (genvar k = 1; k < NS; k++)
    begin : g_div
        localparam int BIT = qslerp_pkg::DIV_BITS - k;
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [NW-1:0] sub;
            logic          take;
            assign sub  = den_reg[k-1] << BIT;
            assign take = rem_reg[k-1][l] >= sub;
            assign rem_next[k][l] = take ? (rem_reg[k-1][l] - sub) : rem_reg[k-1][l];
            assign q_next[k][l]   = q_reg[k-1][l] | (15'(take) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_reg[0]   <= neg_in;
            sat_reg[0]   <= sat_in;
            den_reg[0]   <= den_in;
            lin_reg[0]   <= lin_in;
            carry_reg[0] <= in_carry;
            for (int k = 0; k < NS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
            end
            for (int k = 1; k < NS; k++)
            begin
                neg_reg[k]   <= neg_reg[k-1];
                sat_reg[k]   <= sat_reg[k-1];
                den_reg[k]   <= den_reg[k-1];
                lin_reg[k]   <= lin_reg[k-1];
                carry_reg[k] <= carry_reg[k-1];
            end
        end
    end

    logic [1:0][14:0] w_div;

    for (genvar l = 0; l < 2; l++)
    begin : g_out
        assign w_div[l] = neg_reg[NS-1][l] ? 15'd0
                        : sat_reg[NS-1][l] ? 15'(qslerp_pkg::Q_ONE)
                        : q_reg[NS-1][l];
    end

    assign out_valid = v_reg[NS-1];
    assign out_carry = carry_reg[NS-1];
    assign out_wa    = lin_reg[NS-1] ? (15'(qslerp_pkg::Q_ONE) - carry_reg[NS-1].t) : w_div[0];
    assign out_wb    = lin_reg[NS-1] ? carry_reg[NS-1].t : w_div[1];

endmodule

### rtl/quaternion_slerp.sv
// Square-root stages: S = 15 + max(COMP_WIDTH - 14, 0). Throughput: one beat per cycle
// while no finished result is stalled at the output register.
// The whole pipeline holds while a finished result is stalled at the output register.
// Reset clears every valid bit and sets linear_threshold to 16302; no clearing pass.
// Quaternion slerp top level: configuration register, angle stages and final blend.
// Depends on qslerp_pkg, qslerp_front, qslerp_isqrt, qslerp_cordic and qslerp_weight.
module quaternion_slerp #(
    parameter int COMP_WIDTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  qslerp_pkg::req_t                     req_data,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output qslerp_pkg::rsp_t                     rsp_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [qslerp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [qslerp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [qslerp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                 pready
);

    localparam int UP_SHIFT   = (COMP_WIDTH >= 14) ? COMP_WIDTH - 14 : 0;
    localparam int DOWN_SHIFT = (COMP_WIDTH >= 14) ? 0 : 14 - COMP_WIDTH;
    localparam int W          = COMP_WIDTH + 3;
    localparam int NB         = 29 + 2 * UP_SHIFT;
    localparam int RB         = (NB + 1) / 2;
    localparam int CARRY_W    = $bits(qslerp_pkg::carry_t);
    localparam int SQ_SIDE_W  = CARRY_W + 14;

    logic        adv;
    logic [14:0] threshold_reg;
    logic        cfg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[qslerp_pkg::APB_ADDR_W-1] == qslerp_pkg::REG_LINEAR_THRESHOLD);
    assign prdata = (paddr[qslerp_pkg::APB_ADDR_W-1] == qslerp_pkg::REG_LINEAR_THRESHOLD)
                    ? qslerp_pkg::APB_DATA_W'(threshold_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= qslerp_pkg::THRESHOLD_RESET;
        end
        else if (cfg_wr)
        begin
            threshold_reg <= pwdata[14:0];
        end
    end

    // Every stage moves unless the output register holds a stalled beat.
    logic rsp_valid_reg;
    assign adv       = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !adv;

    logic               fe_valid;
    logic [28:0]        fe_rad;
    logic [13:0]        fe_dot;
    qslerp_pkg::carry_t fe_carry;

    qslerp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (req_valid),
        .in_data   (req_data),
        .threshold (threshold_reg),
        .out_valid (fe_valid),
        .out_rad   (fe_rad),
        .out_dot   (fe_dot),
        .out_carry (fe_carry)
    );

    logic                 sq_valid;
    logic [RB-1:0]        sq_root;
    logic [SQ_SIDE_W-1:0] sq_side;

    qslerp_isqrt #(
        .NB     (NB),
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fe_valid),
        .in_n      (NB'(fe_rad) << (2 * UP_SHIFT)),
        .in_side   ({fe_carry, fe_dot}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    logic [0:0][W-1:0] vec_x, vec_y, vec_z, vec_angle;
    logic              vec_valid;
    logic [CARRY_W-1:0] vec_side;

    assign vec_x[0] = (W'(sq_side[13:0]) << UP_SHIFT) >> DOWN_SHIFT;
    assign vec_y[0] = W'(sq_root >> DOWN_SHIFT);
    assign vec_z[0] = '0;

    qslerp_cordic #(
        .W      (W),
        .STEPS  (CORDIC_STEPS),
        .FRAC   (COMP_WIDTH),
        .LANES  (1),
        .SIDE_W (CARRY_W),
        .MODE   (qslerp_pkg::CORDIC_VECTOR)
    ) u_acos (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_x      (vec_x),
        .in_y      (vec_y),
        .in_z      (vec_z),
        .in_side   (sq_side[SQ_SIDE_W-1:14]),
        .out_valid (vec_valid),
        .out_res   (vec_angle),
        .out_side  (vec_side)
    );

    // Split theta by the blend factor.
    logic                 th_valid_reg;
    logic signed [W-1:0]  theta_reg;
    logic signed [W-1:0]  thb_reg;
    qslerp_pkg::carry_t   th_carry_reg;
    qslerp_pkg::carry_t   vec_carry;
    logic signed [W+15:0] th_prod;

    assign vec_carry = qslerp_pkg::carry_t'(vec_side);
    assign th_prod   = $signed({1'b0, vec_carry.t}) * $signed(vec_angle[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            th_valid_reg <= vec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            theta_reg    <= vec_angle[0];
            thb_reg      <= W'(th_prod >>> 14);
            th_carry_reg <= vec_carry;
        end
    end

    logic [2:0][W-1:0]  rot_x, rot_y, rot_z, rot_sine;
    logic               rot_valid;
    logic [CARRY_W-1:0] rot_side;

    assign rot_x   = {3{W'(1) << COMP_WIDTH}};
    assign rot_y   = '0;
    assign rot_z[0] = theta_reg;
    assign rot_z[1] = theta_reg - thb_reg;
    assign rot_z[2] = thb_reg;

    qslerp_cordic #(
        .W      (W),
        .STEPS  (CORDIC_STEPS),
        .FRAC   (COMP_WIDTH),
        .LANES  (3),
        .SIDE_W (CARRY_W),
        .MODE   (qslerp_pkg::CORDIC_ROTATE)
    ) u_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (th_valid_reg),
        .in_x      (rot_x),
        .in_y      (rot_y),
        .in_z      (rot_z),
        .in_side   (CARRY_W'(th_carry_reg)),
        .out_valid (rot_valid),
        .out_res   (rot_sine),
        .out_side  (rot_side)
    );

    logic               wt_valid;
    logic [14:0]        wt_wa;
    logic [14:0]        wt_wb;
    qslerp_pkg::carry_t wt_carry;

    qslerp_weight #(
        .W (W)
    ) u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (rot_valid),
        .in_sine   (rot_sine),
        .in_carry  (qslerp_pkg::carry_t'(rot_side)),
        .out_valid (wt_valid),
        .out_wa    (wt_wa),
        .out_wb    (wt_wb),
        .out_carry (wt_carry)
    );

    // Final blend: products, then sum, round and saturate into the output register.
    logic                 mul_valid_reg;
    logic signed [32:0]   pa_reg [4];
    logic signed [32:0]   pb_reg [4];
    logic signed [15:0]   r_sat  [4];
    qslerp_pkg::rsp_t     rsp_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                pa_reg[k] <= 33'($signed({1'b0, wt_wa}) * $signed(wt_carry.a[k]));
                pb_reg[k] <= 33'($signed({1'b0, wt_wb}) * $signed(wt_carry.b[k]));
            end
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_sat
        logic signed [33:0] acc;
        logic signed [19:0] r;
        assign acc = 34'(pa_reg[k]) + 34'(pb_reg[k]) + 34'(qslerp_pkg::ROUND_HALF);
        assign r   = 20'(acc >>> 14);
        assign r_sat[k] = (r > 20'sd32767)  ? 16'sh7fff
                        : (r < -20'sd32768) ? 16'sh8000
                        : r[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mul_valid_reg <= wt_valid;
            rsp_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg.r_x <= r_sat[0];
            rsp_reg.r_y <= r_sat[1];
            rsp_reg.r_z <= r_sat[2];
            rsp_reg.r_w <= r_sat[3];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

### rtl/qslerp_checker.sv
// Port-level checks for quaternion_slerp, attached by the bind statement below.
// Depends on qslerp_pkg and the top level's port list.
module qslerp_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    input  logic                                 req_stall,
    input  qslerp_pkg::req_t                     req_data,
    input  logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    input  qslerp_pkg::rsp_t                     rsp_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [qslerp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [qslerp_pkg::APB_DATA_W-1:0]    pwdata,
    input  logic [qslerp_pkg::APB_DATA_W-1:0]    prdata,
    input  logic                                 pready
);

    logic thr_sel;
    assign thr_sel = paddr[qslerp_pkg::APB_ADDR_W-1] == qslerp_pkg::REG_LINEAR_THRESHOLD;

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
        else $error("result beat changed while stalled");

    // The input side is held back only by a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("input stalled without a stalled result");

    // A threshold write reads back on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && thr_sel)
        |=> (!thr_sel || (prdata[14:0] == $past(pwdata[14:0]))))
        else $error("threshold read-back mismatch");

    // The register is fifteen bits wide; the rest of the read word is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        prdata[qslerp_pkg::APB_DATA_W-1:15] == '0)
        else $error("upper read bits not zero");

endmodule

bind quaternion_slerp qslerp_checker u_qslerp_checker (.*);
